/* rtl/core/pip_pkg.sv */
// Shared types and constants for the point-in-polygon crossing-number unit.
package pip_pkg;

    // Control that travels with every edge request from the front end to the edge pipeline.
    typedef struct packed {
        logic restart;   // first vertex of a polygon: clear the parity, no open edge to test
        logic close;     // last vertex: test the closing edge and deliver the parity
    } edge_ctl_t;

    localparam int unsigned CTL_BITS    = $bits(edge_ctl_t);
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned OUT_BITS    = 8;

endpackage

/* rtl/core/pip_front.sv */
// Front end: accepts vertex requests, keeps polygon state and issues edge requests.
module pip_front #(
    parameter int unsigned W = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic signed [W-1:0]   query_x,
    input  logic signed [W-1:0]   query_y,
    input  logic signed [W-1:0]   vertex_x,
    input  logic signed [W-1:0]   vertex_y,
    input  logic                  first_vertex,
    input  logic                  last_vertex,
    input  logic                  q_full,
    output logic                  q_push,
    output pip_pkg::edge_ctl_t    q_ctl,
    output logic [8*W-1:0]        q_coords
);
    import pip_pkg::*;

    logic signed [W-1:0] point_x_reg, point_y_reg;
    logic signed [W-1:0] start_x_reg, start_y_reg;
    logic signed [W-1:0] prior_x_reg, prior_y_reg;
    logic                open_reg;
    logic                open_next;
    logic                accept;

    logic signed [W-1:0] px, py, sx, sy;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    // Vertices that arrive with no polygon open are dropped here.
    assign q_push   = accept && (first_vertex || open_reg);

    always_comb
    begin
        px = first_vertex ? query_x  : point_x_reg;
        py = first_vertex ? query_y  : point_y_reg;
        sx = first_vertex ? vertex_x : start_x_reg;
        sy = first_vertex ? vertex_y : start_y_reg;
        q_ctl.restart = first_vertex;
        q_ctl.close   = last_vertex;
        // Point, open edge (prior to vertex), then the start vertex for the closing edge.
        q_coords = {sy, sx, vertex_y, vertex_x, prior_y_reg, prior_x_reg, py, px};
        open_next = last_vertex ? 1'b0 : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else if (q_push)
        begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            point_x_reg <= px;
            point_y_reg <= py;
            start_x_reg <= sx;
            start_y_reg <= sy;
            prior_x_reg <= vertex_x;
            prior_y_reg <= vertex_y;
        end
    end

endmodule

/* rtl/core/pip_queue.sv */
// Small first-in first-out queue between the front end and the edge pipeline.
module pip_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);
    import pip_pkg::*;

    localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
        bump = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_BITS'(DEPTH))
        else $error("queue occupancy exceeds its depth");
    assert property (@(posedge clk) disable iff (!rst_n) !(full && empty))
        else $error("queue reports full and empty together");
    assert property (@(posedge clk) disable iff (!rst_n) full && !pop |=> full)
        else $error("queue lost an entry while full and not read");
`endif

endmodule

/* rtl/core/pip_edge_unit.sv */
// One edge crossing test: operand preparation, two products, then the sign compare.
module pip_edge_unit #(
    parameter int unsigned W = 24
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] ax,
    input  logic signed [W-1:0] ay,
    input  logic signed [W-1:0] bx,
    input  logic signed [W-1:0] by,
    input  logic signed [W-1:0] px,
    input  logic signed [W-1:0] py,
    output logic                hit
);
    import pip_pkg::*;

    localparam int unsigned D = W + 1;
    localparam int unsigned P = 2 * D;

    logic signed [W-1:0] lx, ly, ux, uy, lo_x, hi_x;
    logic signed [D-1:0] dx, dy, dpx, dpy;

    logic                span_a_reg, beyond_a_reg, left_a_reg;
    logic signed [D-1:0] dx_reg, dy_reg, dpx_reg, dpy_reg;
    logic                span_b_reg, beyond_b_reg, left_b_reg;
    logic signed [P-1:0] prod1_reg, prod2_reg;
    logic        [P:0]   diff;

    always_comb
    begin
        if (ay <= by)
        begin
            lx = ax; ly = ay; ux = bx; uy = by;
        end
        else
        begin
            lx = bx; ly = by; ux = ax; uy = ay;
        end
        lo_x = (ax < bx) ? ax : bx;
        hi_x = (ax < bx) ? bx : ax;
        dx   = D'(ux) - D'(lx);
        dy   = D'(uy) - D'(ly);
        dpx  = D'(px) - D'(lx);
        dpy  = D'(py) - D'(ly);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span_a_reg   <= (py >= ly) && (py < uy);
            beyond_a_reg <= (px > hi_x);
            left_a_reg   <= (px <= lo_x);
            dx_reg       <= dx;
            dy_reg       <= dy;
            dpx_reg      <= dpx;
            dpy_reg      <= dpy;

            span_b_reg   <= span_a_reg;
            beyond_b_reg <= beyond_a_reg;
            left_b_reg   <= left_a_reg;
            prod1_reg    <= dx_reg * dpy_reg;
            prod2_reg    <= dy_reg * dpx_reg;
        end
    end

    // The point is left of or on the edge when the cross product is not negative.
    assign diff = {prod1_reg[P-1], prod1_reg} - {prod2_reg[P-1], prod2_reg};
    assign hit  = span_b_reg && !beyond_b_reg && (left_b_reg || !diff[P]);

endmodule

/* rtl/core/pip_back.sv */
// Back end: edge test pipeline, crossing parity and the result register.
module pip_back #(
    parameter int unsigned W = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  pip_pkg::edge_ctl_t         q_ctl,
    input  logic [8*W-1:0]             q_coords,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pip_pkg::OUT_BITS-1:0] m_tdata
);
    import pip_pkg::*;

    logic signed [W-1:0] px, py, ax, ay, bx, by, sx, sy;
    logic                adv;
    logic                va_reg, vb_reg;
    edge_ctl_t           ctl_a_reg, ctl_b_reg;
    logic                parity_reg, parity_next;
    logic                out_valid_reg, inside_reg;
    logic                cross_open, cross_close;

    assign {sy, sx, by, bx, ay, ax, py, px} = q_coords;

    // The whole pipeline moves when the result register is free or being emptied.
    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;

    pip_edge_unit #(.W(W)) u_open_edge (
        .clk (clk),
        .en  (adv),
        .ax  (ax),
        .ay  (ay),
        .bx  (bx),
        .by  (by),
        .px  (px),
        .py  (py),
        .hit (cross_open)
    );

    pip_edge_unit #(.W(W)) u_close_edge (
        .clk (clk),
        .en  (adv),
        .ax  (bx),
        .ay  (by),
        .bx  (sx),
        .by  (sy),
        .px  (px),
        .py  (py),
        .hit (cross_close)
    );

    always_comb
    begin
        parity_next = (ctl_b_reg.restart ? 1'b0 : parity_reg)
                    ^ (!ctl_b_reg.restart && cross_open)
                    ^ (ctl_b_reg.close && cross_close);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg        <= !q_empty;
            vb_reg        <= va_reg;
            out_valid_reg <= vb_reg && ctl_b_reg.close;
            if (vb_reg)
            begin
                parity_reg <= parity_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_a_reg <= q_ctl;
            ctl_b_reg <= ctl_a_reg;
            if (vb_reg && ctl_b_reg.close)
            begin
                inside_reg <= parity_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_BITS - 1)'(0), inside_reg};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vb_reg && ctl_b_reg.close))
        else $error("result raised without a closing edge in the last stage");
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv && vb_reg |=> vb_reg && $stable(parity_reg))
        else $error("pipeline moved while the result register was stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && vb_reg && ctl_b_reg.restart && !ctl_b_reg.close |=> parity_reg == 1'b0)
        else $error("parity not cleared at the start of a polygon");
`endif

endmodule

/* rtl/core/point_in_polygon_ray_cast_unit.sv */
// Top level of the streaming point-in-polygon crossing-number unit.
//
// Usage: each request on the slave channel carries one polygon vertex together with
// the query point. tuser marks the first vertex of a polygon, which also samples the
// query point; tlast marks the last vertex. Every later vertex tests the edge from
// the previous vertex, and the last one also tests the closing edge back to the first
// vertex. One result request, inside or not by the even-odd rule, leaves on the master
// channel for every completed polygon. A vertex that arrives with no polygon open is
// dropped, and a new first vertex abandons an unfinished polygon without a result.
// Throughput is one vertex per cycle while the queue has room. The last vertex, once
// accepted, passes through the queue, operand preparation, then the products
// of the open-edge and closing-edge units, with the compare feeding the result register.
// A four-entry queue separates the front end from the edge pipeline, so s_tready
// falls only once the queue has filled behind a stalled master channel; while a
// result waits with m_tready low, it holds and the pipeline waits.
// Reset clears the polygon state, the queue and the result register; no result is
// pending after reset.
module point_in_polygon_ray_cast_unit #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // query_x, query_y, vertex_x, vertex_y from the lowest bit up, zero padded to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // first_vertex
    input  logic [0:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inside_res in bit 0, zero padded to a byte
    output logic [pip_pkg::OUT_BITS-1:0]  m_tdata
);
    import pip_pkg::*;

    localparam int unsigned W       = COORD_BITS;
    localparam int unsigned Q_WIDTH = 8 * W + CTL_BITS;

    logic signed [W-1:0] query_x, query_y, vertex_x, vertex_y;
    logic                q_full, q_empty, q_push, q_pop;
    edge_ctl_t           push_ctl, head_ctl;
    logic [8*W-1:0]      push_coords, head_coords;
    logic [Q_WIDTH-1:0]  head_data;

    assign query_x  = s_tdata[0*W +: W];
    assign query_y  = s_tdata[1*W +: W];
    assign vertex_x = s_tdata[2*W +: W];
    assign vertex_y = s_tdata[3*W +: W];

    // Front end: tracks the open polygon and turns each vertex into an edge request.
    pip_front #(.W(W)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .query_x      (query_x),
        .query_y      (query_y),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .first_vertex (s_tuser[0]),
        .last_vertex  (s_tlast),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_ctl        (push_ctl),
        .q_coords     (push_coords)
    );

    // Edge requests wait here so that the front end keeps running while the
    // master channel stalls.
    pip_queue #(.WIDTH(Q_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_ctl, push_coords}),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {head_ctl, head_coords} = head_data;

    // Back end: the open-edge and closing-edge test lanes and the parity.
    pip_back #(.W(W)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_ctl    (head_ctl),
        .q_coords (head_coords),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sim/point_in_polygon_ray_cast_unit_tb.sv */
// Self-checking testbench for the streaming point-in-polygon crossing-number unit.
`timescale 1ns / 1ps

module point_in_polygon_ray_cast_unit_tb;

    localparam int COORD_BITS = 24;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 212;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_MIN = coord_t'(24'h800000);
    localparam coord_t COORD_MAX = coord_t'(24'h7fffff);

    // Keeps its own copy of the polygon state, works out the parity that each closed
    // polygon should give and compares it with the results as they are accepted.
    class parity_scoreboard;
        coord_t point_x, point_y, start_x, start_y, prior_x, prior_y;
        bit     parity;
        bit     open_poly;
        bit     inside_due[$];
        int     errors;

        function new();
            point_x = '0; point_y = '0;
            start_x = '0; start_y = '0;
            prior_x = '0; prior_y = '0;
            parity = 1'b0;
            open_poly = 1'b0;
            errors = 0;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Half-open rule: the lower endpoint counts, the upper does not, and a point
        // left of or on the edge is taken as crossing.
        function bit edge_crossed(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                  coord_t px, coord_t py);
            longint lx, ly, ux, uy, lo_x, hi_x;
            if (ay <= by)
            begin
                lx = ax; ly = ay; ux = bx; uy = by;
            end
            else
            begin
                lx = bx; ly = by; ux = ax; uy = ay;
            end
            if (longint'(py) < ly || longint'(py) >= uy)
                return 1'b0;
            lo_x = (ax < bx) ? longint'(ax) : longint'(bx);
            hi_x = (ax < bx) ? longint'(bx) : longint'(ax);
            if (longint'(px) > hi_x)
                return 1'b0;
            if (longint'(px) <= lo_x)
                return 1'b1;
            // Differences fit in 25 bits, so both products stay well inside 64 bits.
            return ((ux - lx) * (longint'(py) - ly) - (uy - ly) * (longint'(px) - lx)) >= 0;
        endfunction

        function void note_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
                                  bit first, bit last);
            if (first)
            begin
                point_x = qx; point_y = qy;
                start_x = vx; start_y = vy;
                prior_x = vx; prior_y = vy;
                parity = 1'b0;
                open_poly = 1'b1;
            end
            else
            begin
                // A stray vertex with no polygon open leaves everything untouched.
                if (!open_poly)
                    return;
                if (edge_crossed(prior_x, prior_y, vx, vy, point_x, point_y))
                    parity = ~parity;
                prior_x = vx; prior_y = vy;
            end
            if (last)
            begin
                if (edge_crossed(vx, vy, start_x, start_y, point_x, point_y))
                    parity = ~parity;
                inside_due.push_back(parity);
                open_poly = 1'b0;
            end
        endfunction

        task check_inside(logic got);
            bit want;
            if (inside_due.size() == 0)
            begin
                report($sformatf("result inside=%b with none outstanding", got));
                return;
            end
            want = inside_due.pop_front();
            if (got !== want)
                report($sformatf("inside_res got %b, expected %b", got, want));
        endtask

        function int pending();
            return inside_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pip_pkg::OUT_BITS-1:0] m_tdata;

    parity_scoreboard board;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off_go = 1'b0;
    int  hold_left = 0;
    int  vertices_sent = 0;
    bit  gen_open = 1'b0;

    point_in_polygon_ray_cast_unit #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 clk = ~clk;

    // Offers one vertex request and waits until the unit takes it. Valid is left high
    // so that a following request can go out back to back.
    task send_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy, bit first, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx, qy, qx};
        s_tuser  <= first;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_vertex(qx, qy, vx, vy, first, last);
        vertices_sent++;
        if (first)
            gen_open = 1'b1;
        if (last)
            gen_open = 1'b0;
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    // Mostly a random value, now and then one of the two extremes.
    function automatic coord_t wide_coord();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return COORD_MIN;
        if (pick == 1)
            return COORD_MAX;
        return any_coord();
    endfunction

    // A coordinate close to base; wraps at the edge of the range.
    function automatic coord_t near_coord(coord_t base, int spread);
        int off;
        off = int'($urandom_range(2 * spread)) - spread;
        return coord_t'(longint'(base) + off);
    endfunction

    // One polygon with random content around the query point. Small spreads make
    // vertices and edges land on the point and on its row, which exercises the ties.
    task send_random_polygon();
        coord_t qx, qy, vx, vy;
        int n, spread, kind;
        bit drop;
        qx = wide_coord();
        qy = wide_coord();
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
        kind = $urandom_range(9);
        spread = (kind < 4) ? 3 : (kind < 8) ? 2000 : 0;
        // Some polygons are cut short and abandoned by the next first vertex.
        drop = ($urandom_range(99) < 8) && (n > 1);
        for (int i = 0; i < n; i++)
        begin
            if (spread == 0)
            begin
                vx = wide_coord();
                vy = wide_coord();
            end
            else
            begin
                vx = near_coord(qx, spread);
                vy = near_coord(qy, spread);
            end
            if (drop && i == n - 1)
                break;
            // The query fields of later vertices are not used; fill them with noise.
            if (i == 0)
                send_vertex(qx, qy, vx, vy, 1'b1, n == 1);
            else
                send_vertex(any_coord(), any_coord(), vx, vy, 1'b0, i == n - 1);
        end
        // Stray vertices between polygons must be ignored, even with tlast set.
        if (!gen_open && $urandom_range(99) < 6)
            send_vertex(any_coord(), any_coord(), any_coord(), any_coord(), 1'b0,
                        1'($urandom_range(1)));
    endtask

    task random_phase(int idle_pct, int stall_pct, bit with_hold_off);
        int target;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_hold_off)
            hold_off_go = 1'b1;
        target = vertices_sent + RANDOM_PER_PHASE;
        while (vertices_sent < target)
            send_random_polygon();
    endtask

    // Result side: checks every accepted result and draws tready for the next cycle.
    // A long hold-off, counted here, lets the queue fill so the unit stalls its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_inside(m_tdata[0]);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !rst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, no idling on either side.
        // A stray last vertex before any polygon is open gives nothing.
        send_vertex(24'sd7, 24'sd7, 24'sd1, 24'sd1, 1'b0, 1'b1);
        // A single vertex polygon closes on itself and is never inside.
        send_vertex(24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1);
        // Square with the point in the middle.
        send_vertex(24'sd5, 24'sd5, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd10, 24'sd0, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd10, 24'sd10, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, 24'sd10, 1'b0, 1'b1);
        // An unfinished polygon dropped by a new first vertex.
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        // Full-range triangle with the point at the far right.
        send_vertex(COORD_MAX, 24'sd0, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(24'sd0, 24'sd0, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, COORD_MAX, 1'b0, 1'b1);
        // Point on the right-hand edge of the square.
        send_vertex(24'sd10, 24'sd5, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd10, 24'sd0, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd10, 24'sd10, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, 24'sd10, 1'b0, 1'b1);
        // Point on a vertex of a triangle with a horizontal top edge.
        send_vertex(24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd10, 24'sd10, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, -24'sd10, 24'sd10, 1'b0, 1'b1);
        // Point on the horizontal top edge of the same triangle.
        send_vertex(24'sd0, 24'sd10, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd10, 24'sd10, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, -24'sd10, 24'sd10, 1'b0, 1'b1);
        // Full-range triangle around the origin.
        send_vertex(24'sd0, 24'sd0, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(24'sd0, 24'sd0, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, COORD_MAX, 1'b0, 1'b1);
        // A stray vertex after the polygon has closed.
        send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b0);

        random_phase(51, 0, 1'b0);
        random_phase(0, 51, 1'b0);
        random_phase(11, 11, 1'b0);
        // Back-to-back requests against a long receiver hold-off.
        random_phase(0, 0, 1'b1);

        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // Any result arriving now would have no request behind it.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("point_in_polygon_ray_cast_unit_tb: done, clean");
        else
            $display("point_in_polygon_ray_cast_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("TIMEOUT: run did not complete");
        $display("point_in_polygon_ray_cast_unit_tb: done, errors");
        $finish;
    end

endmodule

/* point_in_polygon_ray_cast_unit.f */
rtl/core/pip_pkg.sv
rtl/core/pip_front.sv
rtl/core/pip_queue.sv
rtl/core/pip_edge_unit.sv
rtl/core/pip_back.sv
rtl/core/point_in_polygon_ray_cast_unit.sv
sim/point_in_polygon_ray_cast_unit_tb.sv
